@@ sv/tcode_pkg.sv @@
// Package with the calibration table, widths, state codes and fixed-point helpers.
`default_nettype none

package tcode_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int FRAC_BITS     = 8;
  localparam int CODE_W        = 16;
  localparam int DEG_W         = 8;
  localparam int TEMP_W        = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  typedef logic [CODE_W-1:0]        code_t;
  typedef logic signed [DEG_W-1:0]  deg_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef struct packed {
    deg_t  deg;
    code_t code;
  } cal_entry_t;

  localparam code_t CAL_CODE [TABLE_ENTRIES] = '{
    16'd28480, 16'd28179, 16'd27851, 16'd27497, 16'd27114, 16'd26702, 16'd26261, 16'd25792,
    16'd25296, 16'd24775, 16'd24232, 16'd23671, 16'd23097, 16'd22515, 16'd21933, 16'd21357,
    16'd20793, 16'd20250, 16'd19733, 16'd19247, 16'd18797, 16'd18387, 16'd18017, 16'd17688,
    16'd17400, 16'd17151, 16'd16938, 16'd16757, 16'd16609, 16'd16487, 16'd16387, 16'd16308
  };

  localparam deg_t CAL_DEG [TABLE_ENTRIES] = '{
    8'sd125, 8'sd120, 8'sd115, 8'sd110, 8'sd105, 8'sd100, 8'sd95,  8'sd90,
    8'sd85,  8'sd80,  8'sd75,  8'sd70,  8'sd65,  8'sd60,  8'sd55,  8'sd50,
    8'sd45,  8'sd40,  8'sd35,  8'sd30,  8'sd25,  8'sd20,  8'sd15,  8'sd10,
    8'sd5,   8'sd0,   -8'sd5,  -8'sd10, -8'sd15, -8'sd20, -8'sd25, -8'sd30
  };

  function automatic int max_deg_step();
    int m;
    int d;
    m = 1;
    for (int i = 1; i < TABLE_ENTRIES; i++) begin
      d = int'(CAL_DEG[i-1]) - int'(CAL_DEG[i]);
      if (d > m) begin
        m = d;
      end
    end
    return m;
  endfunction

  localparam int MAX_DDEG = max_deg_step();
  // The offset inside a segment is below its span, so the quotient stays below
  // the largest degree step times two to the fraction bits.
  localparam int Q_W      = $clog2(MAX_DDEG + 1) + FRAC_BITS;
  localparam int NUM_W    = CODE_W + Q_W;
  localparam int SUM_A    = (DEG_W + FRAC_BITS > Q_W + 1) ? DEG_W + FRAC_BITS : Q_W + 1;
  localparam int SUM_W    = ((SUM_A > TEMP_W) ? SUM_A : TEMP_W) + 1;

  typedef logic [Q_W-1:0] quo_t;

  localparam logic signed [SUM_W-1:0] T_MAX = SUM_W'(2**(TEMP_W-1) - 1);
  localparam logic signed [SUM_W-1:0] T_MIN = SUM_W'(-(2**(TEMP_W-1)));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RD_HI,
    ST_PREP,
    ST_DIV
  } state_t;

  function automatic logic signed [TEMP_W-1:0] fix_temp(deg_t d, quo_t a);
    logic signed [SUM_W-1:0] t;
    logic signed [TEMP_W-1:0] r;
    t = ({{(SUM_W-DEG_W){d[DEG_W-1]}}, d} << FRAC_BITS) + {{(SUM_W-Q_W){1'b0}}, a};
    if (t > T_MAX) begin
      r = T_MAX[TEMP_W-1:0];
    end else if (t < T_MIN) begin
      r = T_MIN[TEMP_W-1:0];
    end else begin
      r = t[TEMP_W-1:0];
    end
    return r;
  endfunction

  localparam logic signed [TEMP_W-1:0] TEMP_TOP    = fix_temp(CAL_DEG[0], '0);
  localparam logic signed [TEMP_W-1:0] TEMP_BOTTOM = fix_temp(CAL_DEG[TABLE_ENTRIES-1], '0);

endpackage

`default_nettype wire

@@ sv/tcode_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module tcode_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [tcode_pkg::NUM_W-1:0]  num,
  input  wire logic [tcode_pkg::CODE_W-1:0] span,
  output logic                           done,
  output tcode_pkg::quo_t                quo
);
  import tcode_pkg::*;

  localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rem     <= num;
        dvs     <= NUM_W'(span) << (Q_W - 1);
        cnt     <= CNT_W'(Q_W - 1);
        quo     <= '0;
      end else if (running) begin
        if (rem >= dvs) begin
          rem <= rem - dvs;
          quo <= {quo[Q_W-2:0], 1'b1};
        end else begin
          quo <= {quo[Q_W-2:0], 1'b0};
        end
        dvs <= dvs >> 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/thermistor_code_to_temperature.sv @@
// Top level: converts a raw sensor code to temperature by table search and interpolation.
//
//   channel   signals                       direction  handshake
//   command   start, busy, raw_code         in         taken when start is high, busy low
//   result    done, temp_q8, saturated      out        one-cycle strobe, cannot be stalled
//
// A code at or beyond a table end gives its result from the check state, with no search.
// Other codes take a binary search over the table memory (a read state and a compare
// state per step), two table reads for the segment ends, and a division for the
// fraction of the segment.
// Synchronous reset clears the control state; the table needs no clearing.
// The block takes one transaction at a time and holds busy until its result is out.
`default_nettype none

module thermistor_code_to_temperature (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [tcode_pkg::CODE_W-1:0]      raw_code,
  output logic                                   done,
  output logic signed [tcode_pkg::TEMP_W-1:0]    temp_q8,
  output logic                                   saturated
);
  import tcode_pkg::*;

  localparam idx_t LAST = IDX_W'(TABLE_ENTRIES - 1);

  state_t     state;
  state_t     state_next;
  idx_t       rom_addr;
  cal_entry_t rom_data;
  logic       div_start;
  logic       div_done;
  quo_t       div_quo;

  code_t      x;
  idx_t       lo;
  idx_t       hi;
  code_t      code_lo;
  deg_t       deg_lo;
  code_t      diff;
  logic       zero_add;

  logic [IDX_W:0]             mid_sum;
  idx_t                       mid;
  logic [DEG_W:0]             ddeg;
  code_t                      span;
  logic [CODE_W+DEG_W-1:0]    prod;
  logic [NUM_W-1:0]           div_num;
  logic                       sat_hi;
  logic                       sat_lo;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IDX_W:1];
  assign ddeg    = {rom_data.deg[DEG_W-1], rom_data.deg} - {deg_lo[DEG_W-1], deg_lo};
  assign span    = rom_data.code - code_lo;
  assign prod    = diff * ddeg[DEG_W-1:0];
  assign div_num = NUM_W'(prod) << FRAC_BITS;
  assign sat_hi  = (x >= CAL_CODE[0]);
  assign sat_lo  = (x <= CAL_CODE[TABLE_ENTRIES-1]);
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    rom_data <= '{deg: CAL_DEG[rom_addr], code: CAL_CODE[rom_addr]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rom_addr   = '0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sat_hi || sat_lo) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (lo == hi) begin
          rom_addr   = lo;
          state_next = ST_RD_HI;
        end else begin
          rom_addr   = mid;
          state_next = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        state_next = ST_SRCH_RD;
      end
      ST_RD_HI: begin
        rom_addr   = lo - IDX_W'(1);
        state_next = ST_PREP;
      end
      ST_PREP: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          x <= raw_code;
        end
      end
      ST_CHECK: begin
        lo <= IDX_W'(1);
        hi <= LAST;
      end
      ST_SRCH_CMP: begin
        if (rom_data.code <= x) begin
          hi <= mid;
        end else begin
          lo <= mid + IDX_W'(1);
        end
      end
      ST_RD_HI: begin
        code_lo <= rom_data.code;
        deg_lo  <= rom_data.deg;
        diff    <= x - rom_data.code;
      end
      ST_PREP: begin
        zero_add <= (rom_data.code <= code_lo) || ddeg[DEG_W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == ST_CHECK && (sat_hi || sat_lo)) begin
        done      <= 1'b1;
        saturated <= 1'b1;
        temp_q8   <= sat_hi ? TEMP_TOP : TEMP_BOTTOM;
      end else if (state == ST_DIV && div_done) begin
        done      <= 1'b1;
        saturated <= 1'b0;
        temp_q8   <= fix_temp(deg_lo, zero_add ? '0 : div_quo);
      end
    end
  end

  tcode_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .span  (span),
    .done  (div_done),
    .quo   (div_quo)
  );

`ifndef SYNTH
  // A result only follows a transaction that was in progress.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // An accepted transaction makes the block busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // In a compare step the search window lies past the first table entry and holds more than one entry.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_CMP) |-> (lo < hi && lo != '0))
    else $error("search window out of range");

  // A saturated result carries one of the table end temperatures.
  assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (temp_q8 == TEMP_TOP || temp_q8 == TEMP_BOTTOM))
    else $error("saturated result is not a table end temperature");
`endif

endmodule

`default_nettype wire

@@ tb/thermistor_code_to_temperature_tb.sv @@
// Testbench for the thermistor code to temperature converter, with a self-checking scoreboard.
module thermistor_code_to_temperature_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcode_pkg::code_t;

  localparam int ENTRIES = 32;
  localparam int FRAC = 8;
  localparam int RANDOM_PER_PHASE = 250;

  localparam code_t CODE_TBL [ENTRIES] = '{
    16'd28480, 16'd28179, 16'd27851, 16'd27497, 16'd27114, 16'd26702, 16'd26261, 16'd25792,
    16'd25296, 16'd24775, 16'd24232, 16'd23671, 16'd23097, 16'd22515, 16'd21933, 16'd21357,
    16'd20793, 16'd20250, 16'd19733, 16'd19247, 16'd18797, 16'd18387, 16'd18017, 16'd17688,
    16'd17400, 16'd17151, 16'd16938, 16'd16757, 16'd16609, 16'd16487, 16'd16387, 16'd16308
  };

  localparam int DEG_TBL [ENTRIES] = '{
    125, 120, 115, 110, 105, 100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
    45, 40, 35, 30, 25, 20, 15, 10, 5, 0, -5, -10, -15, -20, -25, -30
  };

  typedef struct {
    logic signed [15:0] temp;
    logic               sat;
  } reading_t;

  class temp_scoreboard;
    reading_t expected_readings[$];
    int       fail_count;

    function new();
      fail_count = 0;
    endfunction

    function reading_t code_to_temp(code_t c);
      reading_t r;
      int       k;
      int       num;
      int       span;
      int       add;
      int       t;
      r.sat = 1'b0;
      if (c >= CODE_TBL[0]) begin
        t = DEG_TBL[0] * (1 << FRAC);
        r.sat = 1'b1;
      end else if (c <= CODE_TBL[ENTRIES-1]) begin
        t = DEG_TBL[ENTRIES-1] * (1 << FRAC);
        r.sat = 1'b1;
      end else begin
        k = 1;
        while (k < ENTRIES - 1 && CODE_TBL[k] > c) begin
          k++;
        end
        span = int'(CODE_TBL[k-1]) - int'(CODE_TBL[k]);
        num = (int'(c) - int'(CODE_TBL[k])) * (DEG_TBL[k-1] - DEG_TBL[k]) * (1 << FRAC);
        add = (span > 0 && num >= 0) ? num / span : 0;
        t = DEG_TBL[k] * (1 << FRAC) + add;
      end
      if (t > 32767) begin
        t = 32767;
      end
      if (t < -32768) begin
        t = -32768;
      end
      r.temp = 16'(t);
      return r;
    endfunction

    function void note_code(code_t c);
      expected_readings.push_back(code_to_temp(c));
    endfunction

    function void check_reading(logic signed [15:0] temp, logic sat);
      reading_t e;
      if (expected_readings.size() == 0) begin
        $error("unexpected result: temp_q8 %0d, saturated %0b", temp, sat);
        fail_count++;
      end else begin
        e = expected_readings.pop_front();
        if (temp !== e.temp) begin
          $error("temp_q8 mismatch: expected %0d, actual %0d", e.temp, temp);
          fail_count++;
        end
        if (sat !== e.sat) begin
          $error("saturated mismatch: expected %0b, actual %0b", e.sat, sat);
          fail_count++;
        end
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  code_t              raw_code;
  logic               done;
  logic signed [15:0] temp_q8;
  logic               saturated;

  temp_scoreboard sb = new();

  thermistor_code_to_temperature uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .raw_code  (raw_code),
    .done      (done),
    .temp_q8   (temp_q8),
    .saturated (saturated)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_reading(temp_q8, saturated);
    end
  end

  // Each call starts right after a rising edge and returns at the edge that accepts the
  // transaction, leaving start high so that a following transaction can go back to back.
  task automatic send_code(code_t c, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    raw_code <= c;
    do begin
      @(posedge clk);
    end while (busy);
    sb.note_code(c);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic code_t pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 15) begin
      return code_t'(int'(CODE_TBL[$urandom_range(ENTRIES-1)]) + $urandom_range(2) - 1);
    end else if (r < 80) begin
      return code_t'($urandom_range(28490, 16298));
    end else begin
      return code_t'($urandom_range(65535));
    end
  endfunction

  task automatic random_phase(int n, int idle_pct);
    for (int i = 0; i < n; i++) begin
      send_code(pick_code(), idle_pct);
    end
  endtask

  initial begin
    code_t directed [$];
    directed = '{16'd0, 16'd65535, 16'h5555, 16'hAAAA, 16'd28480, 16'd28481, 16'd28479,
                 16'd16308, 16'd16307, 16'd16309, 16'd28179, 16'd26702, 16'd21357,
                 16'd20250, 16'd17151, 16'd16387, 16'd21358, 16'd17150};
    rst      = 1'b1;
    start    = 1'b0;
    raw_code = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_code(directed[i], 0);
    end
    wait_drained();

    random_phase(RANDOM_PER_PHASE, 0);
    random_phase(RANDOM_PER_PHASE, 88);
    wait_drained();
    random_phase(RANDOM_PER_PHASE, 0);
    random_phase(RANDOM_PER_PHASE, 16);

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ thermistor_code_to_temperature.f @@
sv/tcode_pkg.sv
sv/tcode_div.sv
sv/thermistor_code_to_temperature.sv
tb/thermistor_code_to_temperature_tb.sv
